### hw/rtl/olte_pkg.sv
package olte_pkg;

   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_SEARCH = 3'd2,
      OP_GET    = 3'd3,
      OP_MAX    = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_GET,
      RES_SEARCH,
      RES_MAX
   } res_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_SHIFT,
      S_INS_WRITE,
      S_REM_SHIFT,
      S_SCAN,
      S_GET_WAIT,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic         capture;
      logic         init_up;
      logic         init_down;
      logic         init_scan;
      logic         step;
      logic         read_pos;
      logic         wr_value;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         cnt_clear;
      logic         set_result;
      status_type   res_status;
      res_kind_type res_kind;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   ins_bad;
      logic   pos_bad;
      logic   full;
      logic   empty;
      logic   walk_done;
      logic   hit_seen;
   } stat_type;

endpackage

### hw/rtl/olte_req_if.sv
interface olte_req_if;
   logic                          valid;
   logic                          ready;
   logic [olte_pkg::OP_W-1:0]     op;
   logic [olte_pkg::POS_W-1:0]    position;
   logic signed [olte_pkg::VAL_W-1:0] value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

### hw/rtl/olte_rsp_if.sv
interface olte_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [olte_pkg::STATUS_W-1:0]     status;
   logic [olte_pkg::POS_W-1:0]        found_position;
   logic signed [olte_pkg::VAL_W-1:0] read_value;
   logic [olte_pkg::COUNT_W-1:0]      count;

   modport source (output valid, output status, output found_position, output read_value,
                   output count, input ready);
   modport sink   (input valid, input status, input found_position, input read_value,
                   input count, output ready);
endinterface

### hw/rtl/olte_ctrl.sv
module olte_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               out_free,
   input  olte_pkg::stat_type stat,
   output logic               req_ready,
   output logic               out_load,
   output olte_pkg::cmd_type  cmd
);

   olte_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olte_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         olte_pkg::S_IDLE: begin
            if (req_valid) state_in = olte_pkg::S_DECODE;
         end
         olte_pkg::S_DECODE: begin
            case (stat.op)
               olte_pkg::OP_INSERT: begin
                  state_in = (stat.ins_bad || stat.full) ? olte_pkg::S_RESPOND
                                                         : olte_pkg::S_INS_SHIFT;
               end
               olte_pkg::OP_REMOVE: begin
                  state_in = stat.pos_bad ? olte_pkg::S_RESPOND : olte_pkg::S_REM_SHIFT;
               end
               olte_pkg::OP_SEARCH: state_in = olte_pkg::S_SCAN;
               olte_pkg::OP_GET: begin
                  state_in = stat.pos_bad ? olte_pkg::S_RESPOND : olte_pkg::S_GET_WAIT;
               end
               olte_pkg::OP_MAX: begin
                  state_in = stat.empty ? olte_pkg::S_RESPOND : olte_pkg::S_SCAN;
               end
               default: state_in = olte_pkg::S_RESPOND;
            endcase
         end
         olte_pkg::S_INS_SHIFT: begin
            if (stat.walk_done) state_in = olte_pkg::S_INS_WRITE;
         end
         olte_pkg::S_INS_WRITE: state_in = olte_pkg::S_RESPOND;
         olte_pkg::S_REM_SHIFT: begin
            if (stat.walk_done) state_in = olte_pkg::S_RESPOND;
         end
         olte_pkg::S_SCAN: begin
            if (stat.walk_done) state_in = olte_pkg::S_RESPOND;
         end
         olte_pkg::S_GET_WAIT: state_in = olte_pkg::S_RESPOND;
         olte_pkg::S_RESPOND: begin
            if (out_free) state_in = olte_pkg::S_IDLE;
         end
         default: state_in = olte_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.res_status = olte_pkg::ST_OK;
      cmd.res_kind   = olte_pkg::RES_NONE;
      req_ready      = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         olte_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         olte_pkg::S_DECODE: begin
            case (stat.op)
               olte_pkg::OP_INSERT: begin
                  // position check comes before the full check
                  if (stat.ins_bad) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = olte_pkg::ST_BAD_POS;
                  end else if (stat.full) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = olte_pkg::ST_FULL;
                  end else begin
                     cmd.init_up = 1'b1;
                  end
               end
               olte_pkg::OP_REMOVE: begin
                  if (stat.pos_bad) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = olte_pkg::ST_BAD_POS;
                  end else begin
                     cmd.init_down = 1'b1;
                  end
               end
               olte_pkg::OP_SEARCH: cmd.init_scan = 1'b1;
               olte_pkg::OP_GET: begin
                  if (stat.pos_bad) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = olte_pkg::ST_BAD_POS;
                  end else begin
                     cmd.read_pos = 1'b1;
                  end
               end
               olte_pkg::OP_MAX: begin
                  if (stat.empty) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = olte_pkg::ST_EMPTY;
                  end else begin
                     cmd.init_scan = 1'b1;
                  end
               end
               olte_pkg::OP_CLEAR: begin
                  cmd.cnt_clear  = 1'b1;
                  cmd.set_result = 1'b1;
               end
               default: cmd.set_result = 1'b1;
            endcase
         end
         olte_pkg::S_INS_SHIFT: cmd.step = 1'b1;
         olte_pkg::S_INS_WRITE: begin
            cmd.wr_value   = 1'b1;
            cmd.cnt_inc    = 1'b1;
            cmd.set_result = 1'b1;
         end
         olte_pkg::S_REM_SHIFT: begin
            cmd.step = 1'b1;
            if (stat.walk_done) begin
               cmd.cnt_dec    = 1'b1;
               cmd.set_result = 1'b1;
            end
         end
         olte_pkg::S_SCAN: begin
            cmd.step = 1'b1;
            if (stat.walk_done) begin
               cmd.set_result = 1'b1;
               if (stat.op == olte_pkg::OP_SEARCH) begin
                  cmd.res_kind   = olte_pkg::RES_SEARCH;
                  cmd.res_status = stat.hit_seen ? olte_pkg::ST_OK : olte_pkg::ST_NOT_FOUND;
               end else begin
                  cmd.res_kind = olte_pkg::RES_MAX;
               end
            end
         end
         olte_pkg::S_GET_WAIT: begin
            cmd.set_result = 1'b1;
            cmd.res_kind   = olte_pkg::RES_GET;
         end
         olte_pkg::S_RESPOND: out_load = out_free;
         default: ;
      endcase
   end

endmodule

### hw/rtl/olte_dp.sv
module olte_dp #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  olte_pkg::cmd_type               cmd,
   input  logic [olte_pkg::OP_W-1:0]       req_op,
   input  logic [olte_pkg::POS_W-1:0]      req_position,
   input  logic [olte_pkg::VAL_W-1:0]      req_value,
   output olte_pkg::stat_type              stat,
   output logic [olte_pkg::STATUS_W-1:0]   res_status,
   output logic [olte_pkg::POS_W-1:0]      res_fpos,
   output logic [olte_pkg::VAL_W-1:0]      res_rval,
   output logic [olte_pkg::COUNT_W-1:0]    count_out
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((CNT_W > olte_pkg::POS_W) ? CNT_W : olte_pkg::POS_W) + 1;
   localparam int FP_W   = ((CNT_W + 1) > olte_pkg::POS_W) ? (CNT_W + 1) : olte_pkg::POS_W;
   localparam int CO_W   = (CNT_W > olte_pkg::COUNT_W) ? CNT_W : olte_pkg::COUNT_W;

   logic [olte_pkg::VAL_W-1:0]    entries_ff [DEPTH];
   logic [olte_pkg::VAL_W-1:0]    rd_ff;

   logic [olte_pkg::OP_W-1:0]     op_ff;
   logic [olte_pkg::POS_W-1:0]    pos_ff;
   logic [olte_pkg::VAL_W-1:0]    val_ff;

   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              src_ff, src_in;
   logic [CNT_W-1:0]              left_ff, left_in;
   logic [CNT_W-1:0]              pend_idx_ff, pend_idx_in;
   logic                          pend_ff, pend_in;
   logic                          up_ff, up_in;
   logic                          scan_ff, scan_in;
   logic                          hit_ff, hit_in;
   logic [olte_pkg::VAL_W-1:0]    best_ff, best_in;
   logic [CNT_W-1:0]              best_idx_ff, best_idx_in;

   logic [olte_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [olte_pkg::POS_W-1:0]    res_fpos_ff, res_fpos_in;
   logic [olte_pkg::VAL_W-1:0]    res_rval_ff, res_rval_in;

   logic [CMP_W-1:0]              pos_x, cnt_x, pos_m1;
   logic [CNT_W-1:0]              dest_idx;
   logic [FP_W-1:0]               best_pos_x;
   logic [CO_W-1:0]               count_x;
   logic                          take;
   logic                          rd_en, wr_en;
   logic [ADDR_W-1:0]             rd_addr, wr_addr;
   logic [olte_pkg::VAL_W-1:0]    wr_data;

   assign pos_x      = CMP_W'(pos_ff);
   assign cnt_x      = CMP_W'(count_ff);
   assign pos_m1     = pos_x - CMP_W'(1);
   assign dest_idx   = up_ff ? (pend_idx_ff + CNT_W'(1)) : (pend_idx_ff - CNT_W'(1));
   assign best_pos_x = FP_W'(best_idx_ff) + FP_W'(1);
   assign count_x    = CO_W'(count_ff);

   // first equal entry for search, first largest entry for max
   always_comb begin
      if (op_ff == olte_pkg::OP_SEARCH) begin
         take = !hit_ff && (rd_ff == val_ff);
      end else begin
         take = !hit_ff || ($signed(rd_ff) > $signed(best_ff));
      end
   end

   always_comb begin
      src_in        = src_ff;
      left_in       = left_ff;
      pend_idx_in   = pend_idx_ff;
      pend_in       = pend_ff;
      up_in         = up_ff;
      scan_in       = scan_ff;
      hit_in        = hit_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_fpos_in   = res_fpos_ff;
      res_rval_in   = res_rval_ff;
      rd_en         = 1'b0;
      rd_addr       = src_ff[ADDR_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = dest_idx[ADDR_W-1:0];
      wr_data       = rd_ff;

      if (cmd.init_up) begin
         src_in  = count_ff - CNT_W'(1);
         left_in = CNT_W'(cnt_x - pos_x + CMP_W'(1));
         up_in   = 1'b1;
         scan_in = 1'b0;
         pend_in = 1'b0;
      end
      if (cmd.init_down) begin
         src_in  = CNT_W'(pos_x);
         left_in = CNT_W'(cnt_x - pos_x);
         up_in   = 1'b0;
         scan_in = 1'b0;
         pend_in = 1'b0;
      end
      if (cmd.init_scan) begin
         src_in  = '0;
         left_in = count_ff;
         up_in   = 1'b0;
         scan_in = 1'b1;
         pend_in = 1'b0;
         hit_in  = 1'b0;
      end

      // one entry read per cycle; its data lands in rd_ff for the next cycle
      if (cmd.step) begin
         if (left_ff != '0) begin
            rd_en       = 1'b1;
            rd_addr     = src_ff[ADDR_W-1:0];
            pend_idx_in = src_ff;
            src_in      = up_ff ? (src_ff - CNT_W'(1)) : (src_ff + CNT_W'(1));
            left_in     = left_ff - CNT_W'(1);
            pend_in     = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            if (scan_ff) begin
               if (take) begin
                  hit_in      = 1'b1;
                  best_in     = rd_ff;
                  best_idx_in = pend_idx_ff;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = dest_idx[ADDR_W-1:0];
               wr_data = rd_ff;
            end
         end
      end

      if (cmd.read_pos) begin
         rd_en   = 1'b1;
         rd_addr = pos_m1[ADDR_W-1:0];
      end
      if (cmd.wr_value) begin
         wr_en   = 1'b1;
         wr_addr = pos_m1[ADDR_W-1:0];
         wr_data = val_ff;
      end

      if (cmd.cnt_inc) count_in = count_ff + CNT_W'(1);
      if (cmd.cnt_dec) count_in = count_ff - CNT_W'(1);
      if (cmd.cnt_clear) count_in = '0;

      if (cmd.set_result) begin
         res_status_in = cmd.res_status;
         res_fpos_in   = '0;
         res_rval_in   = '0;
         case (cmd.res_kind)
            olte_pkg::RES_GET: res_rval_in = rd_ff;
            olte_pkg::RES_SEARCH: begin
               if (hit_ff) res_fpos_in = best_pos_x[olte_pkg::POS_W-1:0];
            end
            olte_pkg::RES_MAX: begin
               res_fpos_in = best_pos_x[olte_pkg::POS_W-1:0];
               res_rval_in = best_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entries_ff[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         left_ff  <= '0;
         pend_ff  <= 1'b0;
         up_ff    <= 1'b0;
         scan_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
         up_ff    <= up_in;
         scan_ff  <= scan_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      src_ff        <= src_in;
      pend_idx_ff   <= pend_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      res_status_ff <= res_status_in;
      res_fpos_ff   <= res_fpos_in;
      res_rval_ff   <= res_rval_in;
   end

   assign stat.op        = olte_pkg::op_type'(op_ff);
   assign stat.ins_bad   = (pos_x == '0) || (pos_x > (cnt_x + CMP_W'(1)));
   assign stat.pos_bad   = (pos_x == '0) || (pos_x > cnt_x);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.walk_done = (left_ff == '0) && !pend_ff;
   assign stat.hit_seen  = hit_ff;

   assign res_status = res_status_ff;
   assign res_fpos   = res_fpos_ff;
   assign res_rval   = res_rval_ff;
   assign count_out  = count_x[olte_pkg::COUNT_W-1:0];

endmodule

### hw/rtl/ordered_list_table_engine_core.sv
// Channel  Dir  Payload                                         Transfer
// req_ch   in   op[2:0], position[6:0], value[31:0] signed      valid && ready
// rsp_ch   out  status[2:0], found_position[6:0],               valid && ready
//               read_value[31:0] signed, count[6:0]
//
// One request at a time. Insert shifts the entries from the position on up by one, then
// writes the value; remove shifts those after the position down by one; search and max
// walk all stored entries; get reads one entry; clear, unused ops and rejected requests
// respond after decode. The walk moves one entry per cycle through the single read and
// write port of the entry memory. Reset is synchronous and empties the list; stored
// entries are not cleared. A finished result waits in the output register while the
// next request is taken; a stalled rsp_ch holds the controller only at its last step.
module ordered_list_table_engine_core #(
   parameter int DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   olte_req_if.sink   req_ch,
   olte_rsp_if.source rsp_ch
);

   olte_pkg::cmd_type             cmd;
   olte_pkg::stat_type            stat;
   logic                          req_ready;
   logic                          out_load;
   logic                          out_free;
   logic [olte_pkg::STATUS_W-1:0] res_status;
   logic [olte_pkg::POS_W-1:0]    res_fpos;
   logic [olte_pkg::VAL_W-1:0]    res_rval;
   logic [olte_pkg::COUNT_W-1:0]  count_out;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [olte_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [olte_pkg::POS_W-1:0]    rsp_fpos_ff;
   logic [olte_pkg::VAL_W-1:0]    rsp_rval_ff;
   logic [olte_pkg::COUNT_W-1:0]  rsp_count_ff;

   olte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .out_free  (out_free),
      .stat      (stat),
      .req_ready (req_ready),
      .out_load  (out_load),
      .cmd       (cmd)
   );

   olte_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_op       (req_ch.op),
      .req_position (req_ch.position),
      .req_value    (req_ch.value),
      .stat         (stat),
      .res_status   (res_status),
      .res_fpos     (res_fpos),
      .res_rval     (res_rval),
      .count_out    (count_out)
   );

   assign req_ch.ready = req_ready;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= res_status;
         rsp_fpos_ff   <= res_fpos;
         rsp_rval_ff   <= res_rval;
         rsp_count_ff  <= count_out;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.found_position = rsp_fpos_ff;
   assign rsp_ch.read_value     = rsp_rval_ff;
   assign rsp_ch.count          = rsp_count_ff;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int LIST_DEPTH   = 64;
   localparam int POS_MAX      = (1 << olte_pkg::POS_W) - 1;
   localparam int RANDOM_ITEMS = 820;
   localparam int HOLD_AFTER   = 300;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 500000;

   localparam logic [olte_pkg::OP_W-1:0]         OP_SPARE_6 = 3'd6;
   localparam logic [olte_pkg::OP_W-1:0]         OP_SPARE_7 = 3'd7;
   localparam logic signed [olte_pkg::VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;
   localparam logic signed [olte_pkg::VAL_W-1:0] VAL_MAX    = 32'sh7fff_ffff;

   typedef struct packed {
      logic [olte_pkg::OP_W-1:0]         op;
      logic [olte_pkg::POS_W-1:0]        position;
      logic signed [olte_pkg::VAL_W-1:0] value;
   } list_req_type;

   typedef struct packed {
      olte_pkg::status_type              status;
      logic [olte_pkg::POS_W-1:0]        found_position;
      logic signed [olte_pkg::VAL_W-1:0] read_value;
      logic [olte_pkg::COUNT_W-1:0]      count;
   } list_rsp_type;

   typedef struct packed {
      list_req_type req;
      logic         typed;
      list_rsp_type rsp;
   } stim_row_type;

   typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIX} trend_type;

   logic clock = 1'b0;
   logic reset;

   olte_req_if req_ch ();
   olte_rsp_if rsp_ch ();

   ordered_list_table_engine_core #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #4 clock = ~clock;

   // mirror of the list contents and length
   logic signed [olte_pkg::VAL_W-1:0] list_mem [LIST_DEPTH];
   int                                list_len = 0;

   list_rsp_type expected_q [$];
   int           fail_count     = 0;
   int           accepted_count = 0;
   int           burst_left     = 0;
   int           cycle_count    = 0;

   stim_row_type directed_rows [27] = '{
      '{'{olte_pkg::OP_GET,    7'd1, 32'sd0}, 1'b1,
        '{olte_pkg::ST_BAD_POS,   7'd0, 32'sd0, 7'd0}},
      '{'{olte_pkg::OP_REMOVE, 7'd1, 32'sd0}, 1'b1,
        '{olte_pkg::ST_BAD_POS,   7'd0, 32'sd0, 7'd0}},
      '{'{olte_pkg::OP_SEARCH, 7'd0, 32'sd0}, 1'b1,
        '{olte_pkg::ST_NOT_FOUND, 7'd0, 32'sd0, 7'd0}},
      '{'{olte_pkg::OP_MAX,    7'd0, 32'sd0}, 1'b1,
        '{olte_pkg::ST_EMPTY,     7'd0, 32'sd0, 7'd0}},
      '{'{olte_pkg::OP_INSERT, 7'd0, 32'sd5}, 1'b1,
        '{olte_pkg::ST_BAD_POS,   7'd0, 32'sd0, 7'd0}},
      '{'{olte_pkg::OP_INSERT, 7'd2, 32'sd5}, 1'b1,
        '{olte_pkg::ST_BAD_POS,   7'd0, 32'sd0, 7'd0}},
      '{'{olte_pkg::OP_INSERT, 7'd1, VAL_MAX}, 1'b1,
        '{olte_pkg::ST_OK,        7'd0, 32'sd0, 7'd1}},
      '{'{olte_pkg::OP_INSERT, 7'd1, VAL_MIN}, 1'b1,
        '{olte_pkg::ST_OK,        7'd0, 32'sd0, 7'd2}},
      '{'{olte_pkg::OP_INSERT, 7'd3,  -32'sd1},     1'b0, '0},
      '{'{olte_pkg::OP_INSERT, 7'd2,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_GET,    7'd1,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_GET,    7'd4,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_MAX,    7'd0,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_INSERT, 7'd1,  VAL_MAX},     1'b0, '0},
      '{'{olte_pkg::OP_MAX,    7'd0,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_SEARCH, 7'd0,  VAL_MAX},     1'b0, '0},
      '{'{olte_pkg::OP_SEARCH, 7'd0,  -32'sd1},     1'b0, '0},
      '{'{olte_pkg::OP_SEARCH, 7'd0,  32'sd12345},  1'b0, '0},
      '{'{olte_pkg::OP_GET,    7'h7f, 32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_GET,    7'd6,  32'sd0},      1'b0, '0},
      '{'{OP_SPARE_6,          7'h55, 32'sh5555_5555}, 1'b0, '0},
      '{'{OP_SPARE_7,          7'h2a, 32'shaaaa_aaaa}, 1'b0, '0},
      '{'{olte_pkg::OP_REMOVE, 7'd1,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_REMOVE, 7'd4,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_REMOVE, 7'd4,  32'sd0},      1'b0, '0},
      '{'{olte_pkg::OP_CLEAR,  7'd0, 32'sd0}, 1'b1,
        '{olte_pkg::ST_OK,        7'd0, 32'sd0, 7'd0}},
      '{'{olte_pkg::OP_MAX,    7'd0, 32'sd0}, 1'b1,
        '{olte_pkg::ST_EMPTY,     7'd0, 32'sd0, 7'd0}}
   };

   // apply one request to the mirrored list and return its result
   function automatic list_rsp_type apply_list_op(list_req_type rq);
      list_rsp_type r;
      int           p;
      bit           hit;
      r        = '0;
      r.status = olte_pkg::ST_OK;
      p        = int'(rq.position);
      hit      = 1'b0;
      case (rq.op)
         olte_pkg::OP_INSERT: begin
            if (p < 1 || p > list_len + 1) begin
               r.status = olte_pkg::ST_BAD_POS;
            end else if (list_len >= LIST_DEPTH) begin
               r.status = olte_pkg::ST_FULL;
            end else begin
               for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i - 1];
               list_mem[p - 1] = rq.value;
               list_len++;
            end
         end
         olte_pkg::OP_REMOVE: begin
            if (p < 1 || p > list_len) begin
               r.status = olte_pkg::ST_BAD_POS;
            end else begin
               for (int i = p; i < list_len; i++) list_mem[i - 1] = list_mem[i];
               list_len--;
            end
         end
         olte_pkg::OP_SEARCH: begin
            r.status = olte_pkg::ST_NOT_FOUND;
            for (int i = 0; i < list_len; i++) begin
               if (!hit && list_mem[i] == rq.value) begin
                  hit              = 1'b1;
                  r.status         = olte_pkg::ST_OK;
                  r.found_position = olte_pkg::POS_W'(i + 1);
               end
            end
         end
         olte_pkg::OP_GET: begin
            if (p < 1 || p > list_len) r.status = olte_pkg::ST_BAD_POS;
            else r.read_value = list_mem[p - 1];
         end
         olte_pkg::OP_MAX: begin
            if (list_len == 0) begin
               r.status = olte_pkg::ST_EMPTY;
            end else begin
               r.read_value     = list_mem[0];
               r.found_position = olte_pkg::POS_W'(1);
               // strict compare keeps the first of equal maxima
               for (int i = 1; i < list_len; i++) begin
                  if ($signed(list_mem[i]) > $signed(r.read_value)) begin
                     r.read_value     = list_mem[i];
                     r.found_position = olte_pkg::POS_W'(i + 1);
                  end
               end
            end
         end
         olte_pkg::OP_CLEAR: list_len = 0;
         default: ;
      endcase
      r.count = olte_pkg::COUNT_W'(list_len);
      return r;
   endfunction

   function automatic logic signed [olte_pkg::VAL_W-1:0] pick_value();
      logic signed [olte_pkg::VAL_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6: begin
            v = $urandom_range(0, 6);
            v = v - 3;
         end
         7:       v = VAL_MIN;
         8:       v = VAL_MAX;
         default: v = ($urandom_range(0, 1) != 0) ? '0 : '1;
      endcase
      return v;
   endfunction

   // mostly a legal position, otherwise zero or beyond the legal range
   function automatic logic [olte_pkg::POS_W-1:0] pick_position(int valid_hi);
      if (valid_hi >= 1 && $urandom_range(0, 99) < 85)
         return olte_pkg::POS_W'($urandom_range(1, valid_hi));
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return olte_pkg::POS_W'(valid_hi + 1);
         default: return olte_pkg::POS_W'($urandom_range(valid_hi + 1, POS_MAX));
      endcase
   endfunction

   function automatic list_req_type pick_request(trend_type trend);
      list_req_type rq;
      int           roll;
      int           ins_w;
      ins_w       = (trend == TREND_GROW) ? 54 : (trend == TREND_SHRINK) ? 14 : 32;
      roll        = $urandom_range(0, 99);
      rq.value    = pick_value();
      rq.position = olte_pkg::POS_W'($urandom_range(0, POS_MAX));
      if (roll < ins_w) begin
         rq.op       = olte_pkg::OP_INSERT;
         rq.position = pick_position(list_len + 1);
      end else if (roll < 64) begin
         rq.op       = olte_pkg::OP_REMOVE;
         rq.position = pick_position(list_len);
      end else if (roll < 76) begin
         rq.op = olte_pkg::OP_SEARCH;
         if (list_len > 0 && $urandom_range(0, 9) < 6)
            rq.value = list_mem[$urandom_range(0, list_len - 1)];
      end else if (roll < 88) begin
         rq.op       = olte_pkg::OP_GET;
         rq.position = pick_position(list_len);
      end else if (roll < 96) begin
         rq.op = olte_pkg::OP_MAX;
      end else if (roll < 97) begin
         rq.op = olte_pkg::OP_CLEAR;
      end else begin
         rq.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
      end
      return rq;
   endfunction

   // offer one request in bursts with random gaps; predict once it transfers
   task automatic send_request(input list_req_type rq, input logic typed,
                               input list_rsp_type typed_rsp);
      list_rsp_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.op       <= rq.op;
      req_ch.position <= rq.position;
      req_ch.value    <= rq.value;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_list_op(rq);
      accepted_count++;
      expected_q.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic check_field(input string name, input logic signed [olte_pkg::VAL_W-1:0] want,
                              input logic signed [olte_pkg::VAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial begin : stimulus
      list_req_type rq;
      trend_type    trend;
      int           trend_left;
      int           full_tries;
      req_ch.valid    <= 1'b0;
      req_ch.op       <= olte_pkg::OP_INSERT;
      req_ch.position <= '0;
      req_ch.value    <= '0;
      reset           <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      // fill the list, then keep inserting against the full list
      full_tries = 0;
      while (list_len < LIST_DEPTH || full_tries < 6) begin
         if (list_len == LIST_DEPTH) full_tries++;
         rq.op       = olte_pkg::OP_INSERT;
         rq.position = pick_position(list_len + 1);
         rq.value    = pick_value();
         send_request(rq, 1'b0, '0);
      end

      trend      = TREND_MIX;
      trend_left = 0;
      repeat (RANDOM_ITEMS) begin
         if (trend_left == 0) begin
            trend      = trend_type'($urandom_range(0, 2));
            trend_left = $urandom_range(20, 80);
         end
         trend_left--;
         send_request(pick_request(trend), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : rsp_stall
      int run_len;
      int mode;
      int tick;
      bit long_hold_done;
      tick           = 0;
      long_hold_done = 1'b0;
      forever begin
         if (!long_hold_done && accepted_count >= HOLD_AFTER) begin
            // hold off long enough for the block to back up into req_ch
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(4, 60);
            repeat (run_len) begin
               case (mode)
                  0:       rsp_ch.ready <= 1'b1;
                  1:       rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                  2:       rsp_ch.ready <= (tick % 4) != 3;
                  default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
               endcase
               tick++;
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transfer: expected none actual status %0d count %0d",
                     $time, rsp_ch.status, rsp_ch.count);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("found_position", want.found_position, rsp_ch.found_position);
            check_field("read_value", want.read_value, rsp_ch.read_value);
            check_field("count", want.count, rsp_ch.count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, expected_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

### filelist.f
hw/rtl/olte_pkg.sv
hw/rtl/olte_req_if.sv
hw/rtl/olte_rsp_if.sv
hw/rtl/olte_ctrl.sv
hw/rtl/olte_dp.sv
hw/rtl/ordered_list_table_engine_core.sv
sim/testbench.sv
